[hdl/qgp_pkg.sv]
// Package: constants, work word type and arithmetic helpers for the gravity projection.
`default_nettype none
package qgp_pkg;

  localparam int FracBits = 14;
  localparam int CompW    = 16;
  localparam int QuotW    = FracBits + 1;
  localparam int N2W      = 2 * CompW + 1;
  localparam int MagW     = 2 * CompW + 1;
  localparam int SNumW    = MagW + 1;
  localparam int NumW     = MagW + QuotW;
  localparam int DenW     = N2W + 1;
  localparam int RemW     = DenW + 1;
  localparam int Lanes    = 3;
  localparam int Steps    = QuotW;
  localparam int FifoDepth = 2;

  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0] num;
    logic [DenW-1:0]            den;
    logic [Lanes-1:0]           neg;
    logic                       degen;
  } qgp_work_t;

  // Scaled, rounding-biased dividend: |v| * 2^(FracBits+1) + n2.
  function automatic logic [NumW-1:0] qgp_dividend(input logic signed [SNumW-1:0] v,
                                                   input logic [N2W-1:0] n2);
    logic [SNumW-1:0] a;
    a = v[SNumW-1] ? (~v + SNumW'(1)) : v;
    return {a[MagW-1:0], {QuotW{1'b0}}} + NumW'(n2);
  endfunction

endpackage
`default_nettype wire

[hdl/qgp_if.sv]
// Interfaces: quaternion input channel and gravity result channel.
`default_nettype none
interface qgp_quat_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qgp_grav_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] grav_x;
  logic signed [15:0] grav_y;
  logic signed [15:0] grav_z;
  logic              degenerate;
  modport source(output valid, grav_x, grav_y, grav_z, degenerate, input ready);
  modport sink(input valid, grav_x, grav_y, grav_z, degenerate, output ready);
endinterface
`default_nettype wire

[hdl/quaternion_gravity_projection_top.sv]
// Top level of the quaternion gravity projection block.
// Takes one Q2.14 quaternion per cycle when not stalled and returns the
// body-frame down vector (Q2.14, rounded to nearest, within plus or minus one)
// plus a degenerate flag for the all-zero quaternion. Sustained rate is one word
// per cycle when nothing stalls. An input passes in order through the product
// register, which loads on the accept edge, the norm and numerator register,
// one queue entry, the divider load register, fifteen divider stages (one
// quotient bit each) and the output register. The input and output sides stall
// independently through the two-entry queue.
`default_nettype none
module quaternion_gravity_projection_top import qgp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qgp_quat_if.sink   quat_i,
  qgp_grav_if.source grav_o
);

  logic      f_valid, f_ready, b_valid, b_ready;
  qgp_work_t f_work, b_work;

  qgp_front u_front (
    .clk_i, .rst_ni, .quat_i,
    .work_valid_o(f_valid), .work_o(f_work), .work_ready_i(f_ready)
  );

  qgp_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_i(f_work), .in_ready_o(f_ready),
    .out_valid_o(b_valid), .out_o(b_work), .out_ready_i(b_ready)
  );

  qgp_back u_back (
    .clk_i, .rst_ni,
    .work_valid_i(b_valid), .work_i(b_work), .work_ready_o(b_ready),
    .grav_o
  );

endmodule
`default_nettype wire

[hdl/qgp_front.sv]
// Front end: products, squared norm, numerators and zero-norm classification.
`default_nettype none
module qgp_front import qgp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qgp_quat_if.sink  quat_i,
  output logic      work_valid_o,
  output qgp_work_t work_o,
  input  wire logic work_ready_i
);

  logic en;
  logic s1_v_q, s2_v_q;
  logic signed [2*CompW-1:0] ww_q, xx_q, yy_q, zz_q, wy_q, xz_q, wx_q, yz_q;
  qgp_work_t work_d, work_q;
  logic [N2W-1:0] n2;
  logic signed [SNumW-1:0] nx, ny, nz;

  assign en           = !s2_v_q || work_ready_i;
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= quat_i.valid;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q   <= quat_i.quat_w * quat_i.quat_w;
      xx_q   <= quat_i.quat_x * quat_i.quat_x;
      yy_q   <= quat_i.quat_y * quat_i.quat_y;
      zz_q   <= quat_i.quat_z * quat_i.quat_z;
      wy_q   <= quat_i.quat_w * quat_i.quat_y;
      xz_q   <= quat_i.quat_x * quat_i.quat_z;
      wx_q   <= quat_i.quat_w * quat_i.quat_x;
      yz_q   <= quat_i.quat_y * quat_i.quat_z;
      work_q <= work_d;
    end
  end

  always_comb begin
    n2 = N2W'($unsigned(ww_q)) + N2W'($unsigned(xx_q))
       + N2W'($unsigned(yy_q)) + N2W'($unsigned(zz_q));
    nx = (SNumW'(wy_q) - SNumW'(xz_q)) <<< 1;
    ny = -((SNumW'(wx_q) + SNumW'(yz_q)) <<< 1);
    nz = (SNumW'(xx_q) + SNumW'(yy_q)) - (SNumW'(ww_q) + SNumW'(zz_q));
    work_d.num[0] = qgp_dividend(nx, n2);
    work_d.num[1] = qgp_dividend(ny, n2);
    work_d.num[2] = qgp_dividend(nz, n2);
    work_d.neg    = {nz[SNumW-1], ny[SNumW-1], nx[SNumW-1]};
    work_d.den    = {n2, 1'b0};
    work_d.degen  = (n2 == '0);
  end

  assign work_valid_o = s2_v_q;
  assign work_o       = work_q;

endmodule
`default_nettype wire

[hdl/qgp_fifo.sv]
// Two-entry queue between front and back end.
`default_nettype none
module qgp_fifo import qgp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  qgp_work_t in_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output qgp_work_t out_o,
  input  wire logic out_ready_i
);

  qgp_work_t mem_q [FifoDepth];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'(FifoDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end

endmodule
`default_nettype wire

[hdl/qgp_back.sv]
// Back end: pipelined restoring dividers (one quotient bit per stage), sign, clamp.
`default_nettype none
module qgp_back import qgp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  work_valid_i,
  input  qgp_work_t  work_i,
  output logic       work_ready_o,
  qgp_grav_if.source grav_o
);

  localparam logic signed [QuotW+1:0] One = (QuotW+2)'(1) <<< FracBits;

  logic en;
  logic                                st_v_q   [Steps+1];
  logic [Lanes-1:0][RemW-1:0]          st_r_q   [Steps+1];
  logic [Lanes-1:0][QuotW-1:0]         st_nl_q  [Steps+1];
  logic [Lanes-1:0][QuotW-1:0]         st_qt_q  [Steps+1];
  logic [DenW-1:0]                     st_d_q   [Steps+1];
  logic [Lanes-1:0]                    st_neg_q [Steps+1];
  logic                                st_dg_q  [Steps+1];
  logic [Lanes-1:0][RemW-1:0]          rs       [Steps];
  logic [Lanes-1:0]                    ge       [Steps];
  logic out_v_q, dg_q;
  logic signed [CompW-1:0] g_q [Lanes];
  logic signed [CompW-1:0] g_d [Lanes];

  assign en           = !out_v_q || grav_o.ready;
  assign work_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Steps; k++) st_v_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      st_v_q[0] <= work_valid_i;
      for (int k = 0; k < Steps; k++) st_v_q[k+1] <= st_v_q[k];
      out_v_q <= st_v_q[Steps];
    end
  end

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        rs[k][l] = {st_r_q[k][l][RemW-2:0], st_nl_q[k][l][QuotW-1]};
        ge[k][l] = (rs[k][l] >= RemW'(st_d_q[k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < Lanes; l++) begin
        st_r_q[0][l]  <= RemW'(work_i.num[l][NumW-1:QuotW]);
        st_nl_q[0][l] <= work_i.num[l][QuotW-1:0];
        st_qt_q[0][l] <= '0;
      end
      st_d_q[0]   <= work_i.den;
      st_neg_q[0] <= work_i.neg;
      st_dg_q[0]  <= work_i.degen;
      for (int k = 0; k < Steps; k++) begin
        for (int l = 0; l < Lanes; l++) begin
          st_r_q[k+1][l]  <= ge[k][l] ? (rs[k][l] - RemW'(st_d_q[k])) : rs[k][l];
          st_nl_q[k+1][l] <= {st_nl_q[k][l][QuotW-2:0], 1'b0};
          st_qt_q[k+1][l] <= {st_qt_q[k][l][QuotW-2:0], ge[k][l]};
        end
        st_d_q[k+1]   <= st_d_q[k];
        st_neg_q[k+1] <= st_neg_q[k];
        st_dg_q[k+1]  <= st_dg_q[k];
      end
    end
  end

  always_comb begin
    logic signed [QuotW+1:0] s;
    for (int l = 0; l < Lanes; l++) begin
      s = $signed({2'b00, st_qt_q[Steps][l]});
      if (st_neg_q[Steps][l]) s = -s;
      if (s > One) s = One;
      if (s < -One) s = -One;
      g_d[l] = CompW'(s);
    end
    if (st_dg_q[Steps]) begin
      g_d[0] = '0;
      g_d[1] = '0;
      g_d[2] = CompW'(-One);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < Lanes; l++) g_q[l] <= g_d[l];
      dg_q <= st_dg_q[Steps];
    end
  end

  assign grav_o.valid      = out_v_q;
  assign grav_o.grav_x     = g_q[0];
  assign grav_o.grav_y     = g_q[1];
  assign grav_o.grav_z     = g_q[2];
  assign grav_o.degenerate = dg_q;

`ifndef SYNTHESIS
  a_degen_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && dg_q |-> g_q[0] == '0 && g_q[1] == '0 && g_q[2] == CompW'(-One))
    else $error("degenerate word without default vector");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $signed(g_q[0]) <= One && $signed(g_q[0]) >= -One
             && $signed(g_q[2]) <= One && $signed(g_q[2]) >= -One)
    else $error("gravity component out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(st_v_q[Steps]) && $stable(st_dg_q[Steps]))
    else $error("divider pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

[bench/quaternion_gravity_projection_top_tb.sv]
// Testbench: directed and random quaternions checked against table rows or a predictor.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_gravity_projection_top_tb import qgp_pkg::*; ();

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic               degen;
  } grav_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               has_exp;
    grav_t              exp;
  } stim_row_t;

  localparam int One = 1 << FracBits;
  localparam int NumRand = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  qgp_quat_if quat_if ();
  qgp_grav_if grav_if ();

  quaternion_gravity_projection_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .quat_i(quat_if.sink),
    .grav_o(grav_if.source)
  );

  always #4 clk_i = ~clk_i;

  grav_t grav_q[$];
  int    errors = 0;
  int    n_words = 0;
  int    n_degen = 0;
  bit    sink_calm = 1'b0;

  // rounded n * 2^FracBits / d, ties away from zero, clamped to +-1
  function automatic logic signed [15:0] proj_div(input longint n, input longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (2 * (mag << FracBits) + d) / (2 * d);
    if (n < 0) q = -q;
    if (q > One) q = One;
    if (q < -One) q = -One;
    return 16'(q);
  endfunction

  function automatic grav_t project_gravity(input logic signed [15:0] w, x, y, z);
    longint lw, lx, ly, lz, n2;
    grav_t  g;
    lw = w; lx = x; ly = y; lz = z;
    n2 = lw * lw + lx * lx + ly * ly + lz * lz;
    if (n2 == 0) begin
      g = '{gx: 16'sd0, gy: 16'sd0, gz: -16'(One), degen: 1'b1};
    end else begin
      g.gx = proj_div(2 * (lw * ly - lx * lz), n2);
      g.gy = proj_div(-2 * (lw * lx + ly * lz), n2);
      g.gz = proj_div(lx * lx + ly * ly - lw * lw - lz * lz, n2);
      g.degen = 1'b0;
    end
    return g;
  endfunction

  task automatic send_quat(input logic signed [15:0] w, x, y, z, input bit has_exp,
                           input grav_t exp_g);
    grav_t g;
    g = project_gravity(w, x, y, z);
    if (has_exp && g != exp_g)
      $display("%0t: table row disagrees with predictor: exp %h pred %h", $time, exp_g, g);
    quat_if.valid  <= 1'b1;
    quat_if.quat_w <= w;
    quat_if.quat_x <= x;
    quat_if.quat_y <= y;
    quat_if.quat_z <= z;
    @(posedge clk_i);
    while (!quat_if.ready) @(posedge clk_i);
    grav_q.push_back(has_exp ? exp_g : g);
  endtask

  task automatic idle_maybe(input bit calm);
    if (!calm && $urandom_range(99) < 17) begin
      quat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (grav_if.valid && grav_if.ready) begin
        if (grav_q.size() == 0) begin
          $display("%0t: unexpected word %h %h %h %b", $time, grav_if.grav_x,
                   grav_if.grav_y, grav_if.grav_z, grav_if.degenerate);
          errors++;
        end else begin
          grav_t e;
          e = grav_q.pop_front();
          n_words++;
          if (e.degen) n_degen++;
          if (grav_if.grav_x !== e.gx || grav_if.grav_y !== e.gy ||
              grav_if.grav_z !== e.gz || grav_if.degenerate !== e.degen) begin
            $display("%0t: mismatch exp %0d %0d %0d %b act %0d %0d %0d %b", $time,
                     e.gx, e.gy, e.gz, e.degen, grav_if.grav_x, grav_if.grav_y,
                     grav_if.grav_z, grav_if.degenerate);
            errors++;
          end
        end
      end
      grav_if.ready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  stim_row_t dir_tab[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b1}},
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0},
    '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b0, '0},
    '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
    '{-16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b0, '0},
    '{16'sd3, 16'sd0, 16'sd0, 16'sd1, 1'b0, '0}
  };

  initial begin
    logic signed [15:0] c[4];
    int r;
    quat_if.valid = 1'b0;
    quat_if.quat_w = '0; quat_if.quat_x = '0; quat_if.quat_y = '0; quat_if.quat_z = '0;
    grav_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      idle_maybe(1'b0);
      send_quat(dir_tab[i].w, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                dir_tab[i].has_exp, dir_tab[i].exp);
    end
    // hold off until everything drains
    quat_if.valid <= 1'b0;
    while (grav_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < NumRand; i++) begin
      sink_calm = (i >= 200 && i < 300);
      if (!sink_calm) idle_maybe(1'b0);
      for (int k = 0; k < 4; k++) begin
        r = $urandom_range(9);
        if (r == 0) c[k] = 16'sd0;
        else if (r < 3) c[k] = 16'($signed($urandom_range(0, 64)) - 32);
        else if (r < 5) c[k] = 16'($urandom_range(0, 32767)) ^ 16'h8000;
        else c[k] = 16'($urandom());
      end
      if ($urandom_range(49) == 0) c = '{default: 16'sd0};
      send_quat(c[0], c[1], c[2], c[3], 1'b0, '0);
    end
    quat_if.valid <= 1'b0;
    sink_calm = 1'b0;
    while (grav_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d gravity words (%0d degenerate) from directed and random quaternions",
             n_words, n_degen);
    if (errors == 0 && grav_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[quaternion_gravity_projection_top.f]
hdl/qgp_pkg.sv
hdl/qgp_if.sv
hdl/qgp_front.sv
hdl/qgp_fifo.sv
hdl/qgp_back.sv
hdl/quaternion_gravity_projection_top.sv
bench/quaternion_gravity_projection_top_tb.sv
